### rtl/csnd_pkg.sv
// Shared types and constants for the cycling sensor notification decoder.
`default_nettype none
package csnd_pkg;

    // Field widths
    localparam int TYPE_W  = 2;
    localparam int PAY_W   = 56;
    localparam int LEN_W   = 8;
    localparam int MS_W    = 32;
    localparam int HALF_W  = 16;
    localparam int KIND_W  = 2;

    // Divider geometry: 32-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DIVD_W  = 32;
    localparam int DIVS_W  = 16;
    localparam int DCNT_W  = $clog2(DIVD_W);

    // Cadence scale: 1024 ticks per second times 60 seconds
    localparam logic [DIVD_W-1:0] CAD_SCALE = 32'd61440;
    localparam logic [HALF_W-1:0] HOLD_RESET = 16'd1200;

    // Minimum packet lengths
    localparam logic [LEN_W-1:0] LEN_WHEEL = 8'd7;
    localparam logic [LEN_W-1:0] LEN_CRANK = 8'd5;
    localparam logic [LEN_W-1:0] LEN_HR    = 8'd2;

    // Source codes
    localparam logic [TYPE_W-1:0] SRC_CYC0 = 2'd0;
    localparam logic [TYPE_W-1:0] SRC_CYC1 = 2'd1;
    localparam logic [TYPE_W-1:0] SRC_HR   = 2'd2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_WHEEL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CADENCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HR      = 2'd2;

    // Classified packet
    typedef enum logic [1:0] {
        PKT_NONE  = 2'd0,
        PKT_WHEEL = 2'd1,
        PKT_CRANK = 2'd2,
        PKT_HR    = 2'd3
    } pkt_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // take the input item
        logic mul;        // register revolution delta times scale
        logic div_start;  // launch the serial divider
        logic finish;     // update state and load the output register
    } csnd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        pkt_kind_t kind;
        logic      tdelta_zero;
        logic      div_done;
        logic      out_free;
    } csnd_sts_t;

endpackage
`default_nettype wire

### rtl/csnd_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module csnd_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [csnd_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [csnd_pkg::DIVS_W-1:0]   divisor,
    output logic      [csnd_pkg::DIVD_W-1:0]   quotient,
    output logic                               done
);
    import csnd_pkg::*;

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   trial;

    // One shift-subtract step
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVD_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!trial[DIVS_W]) begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers, no reset needed
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

### rtl/csnd_ctrl.sv
// Controller state machine for the notification decoder.
`default_nettype none
module csnd_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire csnd_pkg::csnd_sts_t   sts,
    output csnd_pkg::csnd_cmd_t        cmd
);
    import csnd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.kind == PKT_NONE) begin
                    state_next = ST_IDLE;
                end else if (sts.kind == PKT_CRANK && !sts.tdelta_zero) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

### rtl/csnd_dp.sv
// Datapath: input capture, decode, crank state, cadence math and output register.
`default_nettype none
module csnd_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire csnd_pkg::csnd_cmd_t           cmd,
    output csnd_pkg::csnd_sts_t                sts,
    input  wire logic [csnd_pkg::TYPE_W-1:0]   s_req_type,
    input  wire logic [csnd_pkg::PAY_W-1:0]    s_payload,
    input  wire logic [csnd_pkg::LEN_W-1:0]    s_packet_length,
    input  wire logic [csnd_pkg::MS_W-1:0]     s_now_ms,
    input  wire logic                          cfg_valid,
    input  wire logic [csnd_pkg::HALF_W-1:0]   cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [csnd_pkg::KIND_W-1:0]   m_result_kind,
    output logic      [csnd_pkg::MS_W-1:0]     m_wheel_revs,
    output logic      [csnd_pkg::HALF_W-1:0]   m_wheel_event_time,
    output logic      [csnd_pkg::HALF_W-1:0]   m_cadence_rpm,
    output logic      [csnd_pkg::HALF_W-1:0]   m_crank_revs,
    output logic      [csnd_pkg::HALF_W-1:0]   m_heart_rate
);
    import csnd_pkg::*;

    // Captured item
    logic [TYPE_W-1:0] type_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [MS_W-1:0]   now_reg;

    // Configuration and crank state
    logic [HALF_W-1:0] hold_reg;
    logic [HALF_W-1:0] prev_revs_reg;
    logic [HALF_W-1:0] prev_time_reg;
    logic [MS_W-1:0]   last_prog_reg;
    logic [HALF_W-1:0] held_reg;

    // Multiplier result
    logic [DIVD_W-1:0] prod_reg;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [MS_W-1:0]   wrevs_reg;
    logic [HALF_W-1:0] wtime_reg;
    logic [HALF_W-1:0] cad_reg;
    logic [HALF_W-1:0] crevs_reg;
    logic [HALF_W-1:0] hr_reg;

    logic [7:0]        flags;
    logic              is_cyc;
    pkt_kind_t         kind;
    logic [HALF_W-1:0] revs;
    logic [HALF_W-1:0] ctime;
    logic [HALF_W-1:0] tdelta;
    logic [HALF_W-1:0] base_revs;
    logic [HALF_W-1:0] rdelta;
    logic [MS_W-1:0]   elapsed;
    logic [DIVD_W-1:0] quotient;
    logic              div_done;
    logic [HALF_W-1:0] cad_new;
    logic [HALF_W-1:0] hr_val;

    // Packet classification
    always_comb begin
        flags  = pay_reg[7:0];
        is_cyc = (type_reg == SRC_CYC0) || (type_reg == SRC_CYC1);
        kind   = PKT_NONE;
        if (is_cyc && flags[0]) begin
            if (len_reg >= LEN_WHEEL) kind = PKT_WHEEL;
        end else if (is_cyc && flags[1]) begin
            if (len_reg >= LEN_CRANK) kind = PKT_CRANK;
        end else if (type_reg == SRC_HR) begin
            if (len_reg >= LEN_HR) kind = PKT_HR;
        end
    end

    // Crank deltas; a zero count means no packet seen yet
    always_comb begin
        revs      = pay_reg[23:8];
        ctime     = pay_reg[39:24];
        tdelta    = ctime - prev_time_reg;
        base_revs = (prev_revs_reg == '0) ? revs : prev_revs_reg;
        rdelta    = revs - base_revs;
        elapsed   = now_reg - last_prog_reg;
    end

    // New cadence: saturated quotient, or held or zeroed when time stands still
    always_comb begin
        if (tdelta != '0) begin
            cad_new = (quotient[DIVD_W-1:HALF_W] != '0) ? '1 : quotient[HALF_W-1:0];
        end else if (elapsed > MS_W'(hold_reg)) begin
            cad_new = '0;
        end else begin
            cad_new = held_reg;
        end
        hr_val = {flags[0] ? pay_reg[23:16] : 8'd0, pay_reg[15:8]};
    end

    csnd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (tdelta),
        .quotient (quotient),
        .done     (div_done)
    );

    // Input capture and product
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= s_req_type;
            pay_reg  <= s_payload;
            len_reg  <= s_packet_length;
            now_reg  <= s_now_ms;
        end
        if (cmd.mul) begin
            prod_reg <= DIVD_W'(rdelta) * CAD_SCALE;
        end
    end

    // Configuration and crank state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= HOLD_RESET;
            prev_revs_reg <= '0;
            prev_time_reg <= '0;
            last_prog_reg <= '0;
            held_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                hold_reg <= cfg_data;
            end
            if (cmd.finish && kind == PKT_CRANK) begin
                prev_revs_reg <= revs;
                held_reg      <= cad_new;
                if (tdelta != '0) begin
                    prev_time_reg <= ctime;
                    last_prog_reg <= now_reg;
                end
            end
        end
    end

    // Output handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (cmd.finish)               out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload; fields foreign to the kind are zero
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            kind_reg  <= KIND_HR;
            wrevs_reg <= '0;
            wtime_reg <= '0;
            cad_reg   <= '0;
            crevs_reg <= '0;
            hr_reg    <= '0;
            case (kind)
                PKT_WHEEL: begin
                    kind_reg  <= KIND_WHEEL;
                    wrevs_reg <= pay_reg[39:8];
                    wtime_reg <= pay_reg[55:40];
                end
                PKT_CRANK: begin
                    kind_reg  <= KIND_CADENCE;
                    cad_reg   <= cad_new;
                    crevs_reg <= revs;
                end
                default: begin
                    hr_reg <= hr_val;
                end
            endcase
        end
    end

    assign sts.kind        = kind;
    assign sts.tdelta_zero = (tdelta == '0);
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || m_ready;

    assign m_valid            = out_valid_reg;
    assign m_result_kind      = kind_reg;
    assign m_wheel_revs       = wrevs_reg;
    assign m_wheel_event_time = wtime_reg;
    assign m_cadence_rpm      = cad_reg;
    assign m_crank_revs       = crevs_reg;
    assign m_heart_rate       = hr_reg;

endmodule
`default_nettype wire

### rtl/cycling_sensor_notification_decoder.sv
// Top level of the cycling sensor notification decoder.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      req_type, payload, packet_length, now_ms
//   m_       out        m_valid / m_ready      result_kind, wheel, cadence, crank, heart rate
//   cfg_     in         cfg_valid / cfg_ready  cadence_hold_ms (16 bit)
//
// Wheel and heart-rate items pass DECODE and OUT; dropped packets return from DECODE to IDLE.
// Crank items with time progress also pass MUL and DIV, where the 32-step serial divider runs.
// Synchronous active-low reset; the hold time returns to 1200 ms, crank state to zero.
// A new item is taken while a result waits on m_; it stalls before its own output load.
`default_nettype none
module cycling_sensor_notification_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [csnd_pkg::TYPE_W-1:0]   s_req_type,
    input  wire logic [csnd_pkg::PAY_W-1:0]    s_payload,
    input  wire logic [csnd_pkg::LEN_W-1:0]    s_packet_length,
    input  wire logic [csnd_pkg::MS_W-1:0]     s_now_ms,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csnd_pkg::HALF_W-1:0]   cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [csnd_pkg::KIND_W-1:0]   m_result_kind,
    output logic      [csnd_pkg::MS_W-1:0]     m_wheel_revs,
    output logic      [csnd_pkg::HALF_W-1:0]   m_wheel_event_time,
    output logic      [csnd_pkg::HALF_W-1:0]   m_cadence_rpm,
    output logic      [csnd_pkg::HALF_W-1:0]   m_crank_revs,
    output logic      [csnd_pkg::HALF_W-1:0]   m_heart_rate
);
    import csnd_pkg::*;

    csnd_cmd_t cmd;
    csnd_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    csnd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csnd_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_req_type         (s_req_type),
        .s_payload          (s_payload),
        .s_packet_length    (s_packet_length),
        .s_now_ms           (s_now_ms),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_wheel_revs       (m_wheel_revs),
        .m_wheel_event_time (m_wheel_event_time),
        .m_cadence_rpm      (m_cadence_rpm),
        .m_crank_revs       (m_crank_revs),
        .m_heart_rate       (m_heart_rate)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the cycling sensor notification decoder.
`timescale 1ns / 1ps

module tb_top;
    import csnd_pkg::*;

    localparam int LIMIT_CYCLES      = 1_000_000;
    localparam int DRAIN_CYCLES      = 64;
    localparam int PHASE_ITEMS       = 250;
    localparam int FIRST_HOLDOFF_AT  = 100;
    localparam int SECOND_HOLDOFF_AT = 900;
    localparam int REPORT_LIMIT      = 10;

    // Source code with no sensor behind it
    localparam logic [TYPE_W-1:0] SRC_NONE = 2'd3;
    // Flag bits of the first packet byte
    localparam logic [7:0] CSC_WHEEL_PRESENT = 8'h01;
    localparam logic [7:0] CSC_CRANK_PRESENT = 8'h02;
    localparam logic [7:0] HR_FORMAT_16      = 8'h01;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [PAY_W-1:0]  payload;
        logic [LEN_W-1:0]  packet_length;
        logic [MS_W-1:0]   now_ms;
    } notification_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MS_W-1:0]   wheel_revs;
        logic [HALF_W-1:0] wheel_time;
        logic [HALF_W-1:0] cadence;
        logic [HALF_W-1:0] crank_revs;
        logic [HALF_W-1:0] heart_rate;
    } decoded_t;

    // DUT ports; the inputs are known from time zero
    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [TYPE_W-1:0]   s_req_type      = '0;
    logic [PAY_W-1:0]    s_payload       = '0;
    logic [LEN_W-1:0]    s_packet_length = '0;
    logic [MS_W-1:0]     s_now_ms        = '0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [HALF_W-1:0]   cfg_data        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [KIND_W-1:0]   m_result_kind;
    logic [MS_W-1:0]     m_wheel_revs;
    logic [HALF_W-1:0]   m_wheel_event_time;
    logic [HALF_W-1:0]   m_cadence_rpm;
    logic [HALF_W-1:0]   m_crank_revs;
    logic [HALF_W-1:0]   m_heart_rate;

    cycling_sensor_notification_decoder dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_payload          (s_payload),
        .s_packet_length    (s_packet_length),
        .s_now_ms           (s_now_ms),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_wheel_revs       (m_wheel_revs),
        .m_wheel_event_time (m_wheel_event_time),
        .m_cadence_rpm      (m_cadence_rpm),
        .m_crank_revs       (m_crank_revs),
        .m_heart_rate       (m_heart_rate)
    );

    // Pending notifications and decoded results still owed by the block
    notification_t pending_items[$];
    decoded_t      expected_results[$];

    // Decoder state as predicted by the testbench
    logic [HALF_W-1:0] crank_prev_revs;
    logic [HALF_W-1:0] crank_prev_time;
    logic [MS_W-1:0]   crank_progress_ms;
    logic [HALF_W-1:0] cadence_held;
    logic [HALF_W-1:0] hold_ms;
    logic              slot_speed [2];

    // Run bookkeeping
    int        items_accepted = 0;
    int        cycle_count    = 0;
    int        fault_count    = 0;
    int        dropped_count, ignored_count, progress_count, saturate_count;
    int        held_count, zeroed_count, hold_writes;
    int        wheel_seen, cadence_seen, hr_seen;
    logic [MS_W-1:0] wall_ms;

    // Sender and receiver pacing
    int burst_left   = 0;
    int gap_left     = 0;
    int mode_left    = 0;
    int stall_pct    = 0;
    int holdoff_left = 0;
    int holdoffs_done = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predict the result of one accepted notification and update decoder state
    task automatic decode_notification(input notification_t n);
        logic [7:0]        flags;
        logic [HALF_W-1:0] revs, ctime, tdelta, rdelta;
        logic [31:0]       quotient;
        decoded_t          r;
        flags = n.payload[7:0];
        r = '0;
        if (n.req_type == SRC_CYC0 || n.req_type == SRC_CYC1) begin
            if ((flags & CSC_WHEEL_PRESENT) != 0) begin
                if (n.packet_length < LEN_WHEEL) begin
                    dropped_count++;
                    return;
                end
                slot_speed[n.req_type[0]] = 1'b1;
                r.kind       = KIND_WHEEL;
                r.wheel_revs = n.payload[39:8];
                r.wheel_time = n.payload[55:40];
            end else if ((flags & CSC_CRANK_PRESENT) != 0) begin
                if (n.packet_length < LEN_CRANK) begin
                    dropped_count++;
                    return;
                end
                slot_speed[n.req_type[0]] = 1'b0;
                revs   = n.payload[23:8];
                ctime  = n.payload[39:24];
                tdelta = ctime - crank_prev_time;
                // zero count means no crank packet seen yet
                if (crank_prev_revs == '0)
                    crank_prev_revs = revs;
                if (tdelta != '0) begin
                    rdelta   = revs - crank_prev_revs;
                    quotient = (32'(rdelta) * CAD_SCALE) / 32'(tdelta);
                    cadence_held = (quotient > 32'h0000_FFFF) ? 16'hFFFF : quotient[15:0];
                    if (quotient > 32'h0000_FFFF)
                        saturate_count++;
                    crank_progress_ms = n.now_ms;
                    crank_prev_time   = ctime;
                    progress_count++;
                end else if (n.now_ms - crank_progress_ms > 32'(hold_ms)) begin
                    cadence_held = '0;
                    zeroed_count++;
                end else begin
                    held_count++;
                end
                crank_prev_revs = revs;
                r.kind       = KIND_CADENCE;
                r.cadence    = cadence_held;
                r.crank_revs = revs;
            end else begin
                dropped_count++;
                return;
            end
        end else if (n.req_type == SRC_HR) begin
            if (n.packet_length < LEN_HR) begin
                dropped_count++;
                return;
            end
            r.kind       = KIND_HR;
            r.heart_rate = {8'h00, n.payload[15:8]};
            if ((flags & HR_FORMAT_16) != 0)
                r.heart_rate[15:8] = n.payload[23:16];
        end else begin
            ignored_count++;
            return;
        end
        expected_results.push_back(r);
    endtask

    function automatic string fmt_result(input decoded_t r);
        return $sformatf("kind %0d wheel %0d/%0d cadence %0d crank %0d hr %0d",
                         r.kind, r.wheel_revs, r.wheel_time, r.cadence,
                         r.crank_revs, r.heart_rate);
    endfunction

    task automatic note_fault(input string what, input decoded_t want, input decoded_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("Mismatch %0d at %0t: %s", fault_count, $time, what);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
        end
    endtask

    // Packet builders
    function automatic logic [PAY_W-1:0] rand_payload();
        return PAY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [PAY_W-1:0] wheel_payload(input logic [7:0] flags,
                                                       input logic [31:0] revs,
                                                       input logic [15:0] wtime);
        return {wtime, revs, flags};
    endfunction

    function automatic logic [PAY_W-1:0] crank_payload(input logic [7:0] flags,
                                                       input logic [15:0] revs,
                                                       input logic [15:0] ctime,
                                                       input logic [15:0] pad);
        return {pad, ctime, revs, flags};
    endfunction

    task automatic push_item(input logic [TYPE_W-1:0] src, input logic [PAY_W-1:0] pay,
                             input logic [LEN_W-1:0] len);
        pending_items.push_back({src, pay, len, wall_ms});
    endtask

    // Random traffic: mostly consistent crank rides, plus wheel, heart rate and noise
    task automatic random_phase(input int count);
        int                made, run, rpm, gap_ms, pick;
        logic [TYPE_W-1:0] slot;
        logic [HALF_W-1:0] revs, ctime, rstep, tstep;
        logic [LEN_W-1:0]  len;
        made = 0;
        wall_ms = ($urandom_range(0, 1) == 0) ? $urandom
                                               : 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run  = $urandom_range(3, 12);
                slot = TYPE_W'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: revs = '0;
                    1: revs = 16'hFFFF - 16'($urandom_range(0, 8));
                    default: revs = 16'($urandom);
                endcase
                ctime = 16'($urandom);
                repeat (run) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            // crank time repeats: land on either side of the hold time
                            rstep  = 16'($urandom_range(0, 1));
                            tstep  = '0;
                            gap_ms = $urandom_range(0, 2 * int'(hold_ms) + 2);
                        end
                        1: begin
                            // big count jump over a tiny interval
                            rstep  = 16'($urandom);
                            tstep  = 16'($urandom_range(1, 3));
                            gap_ms = $urandom_range(0, 5);
                        end
                        2: begin
                            // coasting, no new revolutions
                            rstep  = '0;
                            tstep  = 16'($urandom_range(1, 4000));
                            gap_ms = $urandom_range(100, 2000);
                        end
                        default: begin
                            rstep  = 16'($urandom_range(1, 3));
                            rpm    = $urandom_range(30, 180);
                            tstep  = 16'(61440 * int'(rstep) / rpm);
                            gap_ms = int'(tstep) + $urandom_range(0, 40);
                        end
                    endcase
                    revs    = revs + rstep;
                    ctime   = ctime + tstep;
                    wall_ms = wall_ms + 32'(gap_ms);
                    len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255))
                                                      : 8'($urandom_range(5, 7));
                    push_item(slot, crank_payload((8'($urandom) & ~CSC_WHEEL_PRESENT)
                                                  | CSC_CRANK_PRESENT,
                                                  revs, ctime, 16'($urandom)), len);
                    made++;
                end
            end else if (pick < 75) begin
                wall_ms = wall_ms + 32'($urandom_range(0, 1500));
                if ($urandom_range(0, 9) == 0)
                    len = 8'($urandom_range(0, 6));
                else if ($urandom_range(0, 3) == 0)
                    len = 8'($urandom_range(7, 255));
                else
                    len = LEN_WHEEL;
                push_item(TYPE_W'($urandom_range(0, 1)),
                          wheel_payload(8'($urandom) | CSC_WHEEL_PRESENT, $urandom,
                                        16'($urandom)), len);
                made++;
            end else if (pick < 90) begin
                wall_ms = wall_ms + 32'($urandom_range(0, 1500));
                push_item(SRC_HR, rand_payload(), 8'($urandom_range(0, 9)));
                made++;
            end else begin
                // noise: any source, any bytes, any length
                push_item(TYPE_W'($urandom_range(0, 3)), rand_payload(), 8'($urandom));
            end
        end
    endtask

    // Wait until every pending item is in and every owed result is out
    task automatic settle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_hold(input logic [HALF_W-1:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        hold_ms = value;
        hold_writes++;
    endtask

    // Sender: bursts of items with random gaps in between
    always @(posedge aclk) begin : sender
        notification_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_notification({s_req_type, s_payload, s_packet_length, s_now_ms});
                items_accepted <= items_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item = pending_items.pop_front();
                    s_req_type      <= item.req_type;
                    s_payload       <= item.payload;
                    s_packet_length <= item.packet_length;
                    s_now_ms        <= item.now_ms;
                    s_valid         <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: gap_left = 0;
                            5, 6, 7, 8: gap_left = $urandom_range(1, 8);
                            default: gap_left = $urandom_range(20, 60);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result, stall on a changing duty pattern, hold off twice
    always @(posedge aclk) begin : receiver
        decoded_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_result_kind, m_wheel_revs, m_wheel_event_time, m_cadence_rpm,
                       m_crank_revs, m_heart_rate};
                if (expected_results.size() == 0) begin
                    note_fault("result with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_fault("result differs", want, got);
                    case (want.kind)
                        KIND_WHEEL:   wheel_seen++;
                        KIND_CADENCE: cadence_seen++;
                        default:      hr_seen++;
                    endcase
                end
            end
            // long hold-off so the block backs up into its input
            if (holdoff_left == 0 &&
                ((holdoffs_done == 0 && items_accepted >= FIRST_HOLDOFF_AT) ||
                 (holdoffs_done == 1 && items_accepted >= SECOND_HOLDOFF_AT))) begin
                holdoff_left = $urandom_range(300, 500);
                holdoffs_done++;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                mode_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        crank_prev_revs   = '0;
        crank_prev_time   = '0;
        crank_progress_ms = '0;
        cadence_held      = '0;
        hold_ms           = HOLD_RESET;
        slot_speed[0]     = 1'b0;
        slot_speed[1]     = 1'b0;
        dropped_count = 0; ignored_count = 0; progress_count = 0; saturate_count = 0;
        held_count = 0; zeroed_count = 0; hold_writes = 0;
        wheel_seen = 0; cadence_seen = 0; hr_seen = 0;
        wall_ms = 32'd5000;

        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // heart rate: 8-bit, 16-bit, 16-bit from a short packet, too short
        push_item(SRC_HR, 56'h00_0000_0000_FF00, 8'd2);
        push_item(SRC_HR, 56'h00_0000_00FF_FF01, 8'd3);
        push_item(SRC_HR, 56'h00_0000_0000_3C01, LEN_HR);
        push_item(SRC_HR, 56'hFF_FFFF_FFFF_FFFE, 8'd1);
        push_item(SRC_HR, 56'h0, 8'd0);
        // unused source code, cycling packet without flags, empty cycling packet
        push_item(SRC_NONE, 56'hFF_FFFF_FFFF_FFFF, 8'hFF);
        push_item(SRC_CYC0, 56'hFF_FFFF_FFFF_FFFC, 8'hFF);
        push_item(SRC_CYC1, 56'h0, 8'd0);
        // wheel: short, all ones, both flags with zero data
        push_item(SRC_CYC0, wheel_payload(CSC_WHEEL_PRESENT, 32'hFFFF_FFFF, 16'hFFFF), 8'd6);
        push_item(SRC_CYC0, wheel_payload(8'hFF, 32'hFFFF_FFFF, 16'hFFFF), LEN_WHEEL);
        push_item(SRC_CYC1, wheel_payload(CSC_WHEEL_PRESENT | CSC_CRANK_PRESENT, '0, '0),
                  8'hFF);
        // crank: short, then first packet gives zero cadence
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd100, 16'd1000, '0), 8'd4);
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd100, 16'd1000, '0), LEN_CRANK);
        // one revolution in 1024 ticks, then held, then forced to zero
        wall_ms = 32'd6000;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd101, 16'd2024, '0), LEN_CRANK);
        wall_ms = 32'd6500;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd101, 16'd2024, '0), LEN_CRANK);
        wall_ms = 32'd7201;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd102, 16'd2024, '0), LEN_CRANK);
        // saturation, crank time wrap, count wrap, count back to zero
        wall_ms = 32'd7300;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd5102, 16'd2025, '0), 8'd6);
        wall_ms = 32'd7400;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd5104, 16'd65000, '0), 8'd7);
        wall_ms = 32'd7500;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd5105, 16'd400, '0), LEN_CRANK);
        wall_ms = 32'd7600;
        push_item(SRC_CYC1, crank_payload(CSC_CRANK_PRESENT, 16'hFFFF, 16'd1400, '0), LEN_CRANK);
        wall_ms = 32'd7700;
        push_item(SRC_CYC1, crank_payload(CSC_CRANK_PRESENT, 16'd2, 16'd2400, '0), LEN_CRANK);
        wall_ms = 32'd7800;
        push_item(SRC_CYC1, crank_payload(CSC_CRANK_PRESENT, 16'd0, 16'd3400, '0), LEN_CRANK);
        wall_ms = 32'd7900;
        push_item(SRC_CYC1, crank_payload(CSC_CRANK_PRESENT, 16'd5, 16'd4424, '0), LEN_CRANK);
        wall_ms = 32'd8000;
        push_item(SRC_CYC1, crank_payload(8'hFE, 16'd6, 16'd5448, 16'hFFFF), 8'hFF);
        // repeated time exactly at the hold time, then one past it
        wall_ms = 32'd9200;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd6, 16'd5448, '0), LEN_CRANK);
        wall_ms = 32'd9201;
        push_item(SRC_CYC0, crank_payload(CSC_CRANK_PRESENT, 16'd6, 16'd5448, '0), LEN_CRANK);

        // random phases across hold settings, written only while idle
        for (int k = 0; k < 5; k++) begin
            settle();
            case (k)
                0: write_hold(HOLD_RESET);
                1: write_hold(16'd0);
                2: write_hold(16'hFFFF);
                3: write_hold(16'd1);
                default: write_hold(16'($urandom_range(2, 65534)));
            endcase
            random_phase(PHASE_ITEMS);
        end
        settle();

        $write("Covered %0d items (%0d dropped, %0d ignored); ",
               items_accepted, dropped_count, ignored_count);
        $display("checked %0d wheel, %0d cadence, %0d heart rate results.",
                 wheel_seen, cadence_seen, hr_seen);
        $write("Cadence: %0d from progress (%0d saturated), %0d held, ",
               progress_count, saturate_count, held_count);
        $display("%0d forced to zero; %0d hold writes.", zeroed_count, hold_writes);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/csnd_pkg.sv
rtl/csnd_div.sv
rtl/csnd_ctrl.sv
rtl/csnd_dp.sv
rtl/cycling_sensor_notification_decoder.sv
tb/tb_top.sv
